// ----- src/pvcp_pkg.sv -----
`timescale 1ns / 1ps

package pvcp_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned SqW      = 2 * CoordW;
  localparam int unsigned RootW    = CoordW;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgIdxW  = CfgAddrW - 2;

  localparam logic [CfgIdxW-1:0] RegProjMode = CfgIdxW'(0);

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vec_u;
    coord_t vec_v;
    coord_t vec_w;
  } pvcp_in_t;

  typedef struct packed {
    coord_t proj_x;
    coord_t proj_y;
    coord_t pvec_x;
    coord_t pvec_y;
    logic   saturated;
  } pvcp_out_t;

  // first coordinate of P(p) and P(p+v), y of p and p+v for the XY case
  typedef struct packed {
    coord_t a0;
    coord_t a1;
    coord_t yb0;
    coord_t yb1;
    logic   sat;
  } pvcp_carry_t;

  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } pvcp_root_t;

  typedef struct packed {
    pvcp_carry_t carry;
    pvcp_root_t  rp;
    pvcp_root_t  rq;
  } pvcp_cell_t;

  function automatic coord_t sat_val(input logic signed [CoordW:0] v);
    coord_t res;
    if (v[CoordW] != v[CoordW-1]) begin
      res = v[CoordW] ? CoordMin : CoordMax;
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

  function automatic logic sat_ovf(input logic signed [CoordW:0] v);
    return v[CoordW] ^ v[CoordW-1];
  endfunction

endpackage

// ----- src/pvcp_front.sv -----
`timescale 1ns / 1ps

module pvcp_front import pvcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mode,
  input  logic       up_valid,
  output logic       up_ready,
  input  pvcp_in_t   up,
  output logic       dn_valid,
  input  logic       dn_ready,
  output pvcp_cell_t dn
);

  typedef struct packed {
    logic [CoordW-1:0] ax_p;
    logic [CoordW-1:0] ay_p;
    logic [CoordW-1:0] ax_q;
    logic [CoordW-1:0] ay_q;
  } abs_t;

  typedef struct packed {
    logic [SqW-1:0] xp;
    logic [SqW-1:0] yp;
    logic [SqW-1:0] xq;
    logic [SqW-1:0] yq;
  } sq_t;

  function automatic logic [CoordW-1:0] mag(input coord_t v);
    return v[CoordW-1] ? CoordW'(~v + 1'b1) : CoordW'(v);
  endfunction

  logic signed [CoordW:0] sum_x, sum_y, sum_z;
  coord_t                 qx, qy, qz;

  logic        s1_v_r, s2_v_r, dn_v_r;
  logic        s1_rdy, s2_rdy, s3_rdy;
  pvcp_carry_t s1_carry_r, s1_carry_nxt, s2_carry_r;
  abs_t        s1_abs_r, s1_abs_nxt;
  sq_t         s2_sq_r, s2_sq_nxt;
  pvcp_cell_t  dn_r, dn_nxt;

  assign s3_rdy   = !dn_v_r || dn_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign up_ready = s1_rdy;
  assign dn_valid = dn_v_r;
  assign dn       = dn_r;

  // stage 1: p + v with clamp, magnitudes
  always_comb begin
    sum_x = {up.point_x[CoordW-1], up.point_x} + {up.vec_u[CoordW-1], up.vec_u};
    sum_y = {up.point_y[CoordW-1], up.point_y} + {up.vec_v[CoordW-1], up.vec_v};
    sum_z = {up.point_z[CoordW-1], up.point_z} + {up.vec_w[CoordW-1], up.vec_w};
    qx = sat_val(sum_x);
    qy = sat_val(sum_y);
    qz = sat_val(sum_z);
    s1_carry_nxt.a0  = mode ? up.point_z : up.point_x;
    s1_carry_nxt.a1  = mode ? qz : qx;
    s1_carry_nxt.yb0 = up.point_y;
    s1_carry_nxt.yb1 = qy;
    s1_carry_nxt.sat = sat_ovf(sum_x) | sat_ovf(sum_y) | sat_ovf(sum_z);
    s1_abs_nxt.ax_p  = mag(up.point_x);
    s1_abs_nxt.ay_p  = mag(up.point_y);
    s1_abs_nxt.ax_q  = mag(qx);
    s1_abs_nxt.ay_q  = mag(qy);
  end

  // stage 2: squares
  always_comb begin
    s2_sq_nxt.xp = SqW'(s1_abs_r.ax_p) * SqW'(s1_abs_r.ax_p);
    s2_sq_nxt.yp = SqW'(s1_abs_r.ay_p) * SqW'(s1_abs_r.ay_p);
    s2_sq_nxt.xq = SqW'(s1_abs_r.ax_q) * SqW'(s1_abs_r.ax_q);
    s2_sq_nxt.yq = SqW'(s1_abs_r.ay_q) * SqW'(s1_abs_r.ay_q);
  end

  // stage 3: sums of squares seed the root chain
  always_comb begin
    dn_nxt.carry   = s2_carry_r;
    dn_nxt.rp.rem  = s2_sq_r.xp + s2_sq_r.yp;
    dn_nxt.rp.root = '0;
    dn_nxt.rq.rem  = s2_sq_r.xq + s2_sq_r.yq;
    dn_nxt.rq.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      dn_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= up_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) dn_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && up_valid) begin
      s1_carry_r <= s1_carry_nxt;
      s1_abs_r   <= s1_abs_nxt;
    end
    if (s2_rdy && s1_v_r) begin
      s2_carry_r <= s1_carry_r;
      s2_sq_r    <= s2_sq_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      dn_r <= dn_nxt;
    end
  end

endmodule

// ----- src/pvcp_sqrt_cell.sv -----
`timescale 1ns / 1ps

module pvcp_sqrt_cell import pvcp_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  pvcp_cell_t up,
  output logic       dn_valid,
  input  logic       dn_ready,
  output pvcp_cell_t dn
);

  // decide one root bit: keep it if rem >= (root << (BIT+1)) + 4^BIT
  function automatic pvcp_root_t step(input pvcp_root_t r);
    pvcp_root_t  res;
    logic [SqW:0] trial;
    res   = r;
    trial = ((SqW+1)'(r.root) << (BIT + 1)) | ((SqW+1)'(1) << (2 * BIT));
    if ({1'b0, r.rem} >= trial) begin
      res.rem  = r.rem - trial[SqW-1:0];
      res.root = r.root | (RootW'(1) << BIT);
    end
    return res;
  endfunction

  logic       dn_v_r;
  pvcp_cell_t dn_r, dn_nxt;

  assign up_ready = !dn_v_r || dn_ready;
  assign dn_valid = dn_v_r;
  assign dn       = dn_r;

  always_comb begin
    dn_nxt.carry = up.carry;
    dn_nxt.rp    = step(up.rp);
    dn_nxt.rq    = step(up.rq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_v_r <= 1'b0;
    end else if (up_ready) begin
      dn_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_r <= dn_nxt;
    end
  end

endmodule

// ----- src/pvcp_back.sv -----
`timescale 1ns / 1ps

module pvcp_back import pvcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mode,
  input  logic       up_valid,
  output logic       up_ready,
  input  pvcp_cell_t up,
  output logic       out_valid,
  input  logic       out_ready,
  output pvcp_out_t  out
);

  coord_t                 r0, r1, b0, b1;
  logic                   rsat;
  logic signed [CoordW:0] dx, dy;
  logic                   out_v_r;
  pvcp_out_t              out_r, out_nxt;

  assign up_ready  = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out       = out_r;

  always_comb begin
    r0   = up.rp.root[RootW-1] ? CoordMax : coord_t'(up.rp.root);
    r1   = up.rq.root[RootW-1] ? CoordMax : coord_t'(up.rq.root);
    rsat = mode && (up.rp.root[RootW-1] || up.rq.root[RootW-1]);
    b0   = mode ? r0 : up.carry.yb0;
    b1   = mode ? r1 : up.carry.yb1;
    dx   = {up.carry.a1[CoordW-1], up.carry.a1} - {up.carry.a0[CoordW-1], up.carry.a0};
    dy   = {b1[CoordW-1], b1} - {b0[CoordW-1], b0};
    out_nxt.proj_x    = up.carry.a0;
    out_nxt.proj_y    = b0;
    out_nxt.pvec_x    = sat_val(dx);
    out_nxt.pvec_y    = sat_val(dy);
    out_nxt.saturated = up.carry.sat | rsat | sat_ovf(dx) | sat_ovf(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (up_ready) begin
      out_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- src/point_vector_cylinder_projection_unit.sv -----
`timescale 1ns / 1ps

// Point and vector projection, signed Q16.16.
// in_data carries one point and one displacement vector per item; out_data
// carries the projected point, the projected vector P(p+v) - P(p) and a
// saturation flag. projection_mode (APB offset 0x0, bit 0) picks XY (drop z)
// or ZR (z, radius); change it only while no item is in flight.
// An item passes in order through three front stages (clamped sum,
// squares, sum of squares), a chain of 32 root cells that settles one
// radius bit each, and the output register. Throughput: one item per
// cycle while out_ready is high, set by the fully pipelined cell chain.
// When out_ready is low, items pile up stage by stage and in_ready drops
// only once every stage holds an item; a waiting result never blocks entry
// while a free stage remains.
// Reset (rst_n low, synchronous) empties the pipeline and sets XY mode.
module point_vector_cylinder_projection_unit import pvcp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvcp_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pvcp_out_t           out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic               mode_r;
  logic [CfgIdxW-1:0] cfg_idx;
  logic               cfg_wr;

  logic [RootW:0] chain_v;
  logic [RootW:0] chain_rdy;
  pvcp_cell_t     chain_d [RootW+1];

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CfgAddrW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == RegProjMode) ? CfgDataW'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && cfg_idx == RegProjMode) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  pvcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up       (in_data),
    .dn_valid (chain_v[0]),
    .dn_ready (chain_rdy[0]),
    .dn       (chain_d[0])
  );

  for (genvar k = 0; k < RootW; k++) begin : g_cell
    pvcp_sqrt_cell #(
      .BIT (RootW - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_v[k]),
      .up_ready (chain_rdy[k]),
      .up       (chain_d[k]),
      .dn_valid (chain_v[k+1]),
      .dn_ready (chain_rdy[k+1]),
      .dn       (chain_d[k+1])
    );
  end

  pvcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .up_valid  (chain_v[RootW]),
    .up_ready  (chain_rdy[RootW]),
    .up        (chain_d[RootW]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out       (out_data)
  );

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  a_radius_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r |-> !out_data.proj_y[CoordW-1])
    else $error("negative radius in ZR mode");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- tb/projection_checker.sv -----
`timescale 1ns / 1ps

module projection_checker import pvcp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pvcp_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pvcp_out_t           out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  input  logic [CfgDataW-1:0] cfg_prdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending_cnt
);

  localparam longint S32Hi = 64'sd2147483647;
  localparam longint S32Lo = -64'sd2147483648;
  localparam int     PrintCap = 200;

  pvcp_out_t due_q[$];
  logic      zr_mode;

  initial begin
    fail_count  = 0;
    pending_cnt = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PrintCap) begin
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    end
    fail_count = fail_count + 1;
  endtask

  function automatic longint clip32(input longint v, inout bit sat);
    if (v > S32Hi) begin
      sat = 1'b1;
      return S32Hi;
    end
    if (v < S32Lo) begin
      sat = 1'b1;
      return S32Lo;
    end
    return v;
  endfunction

  // XY keeps (x, y); ZR gives (z, floor(sqrt(x*x + y*y))) clamped to 31 bits
  function automatic void plane_map(input bit zr, input longint x, input longint y,
                                    input longint z, output longint a,
                                    output longint b, inout bit sat);
    logic [63:0] ux, uy, sumsq, root, trial;
    int          i;
    if (!zr) begin
      a = x;
      b = y;
    end else begin
      ux    = (x < 0) ? -x : x;
      uy    = (y < 0) ? -y : y;
      sumsq = ux * ux + uy * uy;
      root  = '0;
      for (i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= sumsq) root = trial;
      end
      if (root > 64'h7FFF_FFFF) begin
        sat  = 1'b1;
        root = 64'h7FFF_FFFF;
      end
      a = z;
      b = longint'(root);
    end
  endfunction

  function automatic pvcp_out_t project_item(input pvcp_in_t d, input bit zr);
    longint    px, py, pz, qx, qy, qz, a0, b0, a1, b1;
    bit        sat;
    pvcp_out_t r;
    sat = 1'b0;
    px  = signed'(d.point_x);
    py  = signed'(d.point_y);
    pz  = signed'(d.point_z);
    qx  = clip32(px + longint'(signed'(d.vec_u)), sat);
    qy  = clip32(py + longint'(signed'(d.vec_v)), sat);
    qz  = clip32(pz + longint'(signed'(d.vec_w)), sat);
    plane_map(zr, px, py, pz, a0, b0, sat);
    plane_map(zr, qx, qy, qz, a1, b1, sat);
    r.proj_x    = a0[31:0];
    r.proj_y    = b0[31:0];
    r.pvec_x    = coord_t'(clip32(a1 - a0, sat));
    r.pvec_y    = coord_t'(clip32(b1 - b0, sat));
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pvcp_out_t want;
    if (!rst_n) begin
      zr_mode <= 1'b0;
      due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with no item pending", out_data.proj_x, '0);
        end else begin
          want = due_q.pop_front();
          if (out_data.proj_x !== want.proj_x)
            report_mismatch("proj_x", out_data.proj_x, want.proj_x);
          if (out_data.proj_y !== want.proj_y)
            report_mismatch("proj_y", out_data.proj_y, want.proj_y);
          if (out_data.pvec_x !== want.pvec_x)
            report_mismatch("pvec_x", out_data.pvec_x, want.pvec_x);
          if (out_data.pvec_y !== want.pvec_y)
            report_mismatch("pvec_y", out_data.pvec_y, want.pvec_y);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
        end
      end
      if (in_valid && in_ready) begin
        due_q.push_back(project_item(in_data, zr_mode));
      end
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CfgAddrW-1:2] == RegProjMode) begin
        if (cfg_pwrite) begin
          zr_mode <= cfg_pwdata[0];
        end else if (cfg_prdata[0] !== zr_mode) begin
          report_mismatch("projection_mode readback", cfg_prdata, 32'(zr_mode));
        end
      end
    end
    pending_cnt <= due_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pvcp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 150;
  localparam int TailCycles    = 40;
  localparam int PhaseItems    = 70;
  localparam int FillItems     = 80;
  localparam int NumCorners    = 12;

  localparam logic [CfgIdxW-1:0] RegUnmapped = CfgIdxW'(1);  // no register here
  localparam coord_t Q1 = 32'sh0001_0000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pvcp_in_t            in_data;
  logic                out_valid;
  logic                out_ready;
  pvcp_out_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  int   fail_count;
  int   pending_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  point_vector_cylinder_projection_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  projection_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending_cnt(pending_cnt)
  );

  always @(posedge clk) begin
    out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(9))
      0, 1, 2, 3: c = $urandom;
      4, 5, 6:    c = $urandom_range(2097152) - 1048576;
      7: begin
        case ($urandom_range(4))
          0:       c = CoordMax;
          1:       c = CoordMin;
          2:       c = '0;
          3:       c = '1;
          default: c = 1;
        endcase
      end
      8:       c = CoordMax - $urandom_range(255);
      default: c = CoordMin + $urandom_range(255);
    endcase
    return c;
  endfunction

  function automatic pvcp_in_t random_item();
    pvcp_in_t d;
    d.point_x = rand_coord();
    d.point_y = rand_coord();
    d.point_z = rand_coord();
    d.vec_u   = rand_coord();
    d.vec_v   = rand_coord();
    d.vec_w   = rand_coord();
    return d;
  endfunction

  function automatic pvcp_in_t corner_item(input int k);
    pvcp_in_t d;
    case (k)
      0:  d = '{0, 0, 0, 0, 0, 0};
      1:  d = '{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax};
      2:  d = '{CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin};
      3:  d = '{CoordMax, CoordMax, CoordMax, 1, Q1, CoordMax};          // sums clamp high
      4:  d = '{CoordMin, CoordMin, CoordMin, -1, CoordMin, -Q1};        // sums clamp low
      5:  d = '{CoordMin, CoordMin, 0, 0, 0, 0};                         // radius clamps
      6:  d = '{CoordMax, CoordMax, Q1, CoordMin, CoordMin, 0};
      7:  d = '{3 * Q1, 4 * Q1, -2 * Q1, Q1, -Q1, 5 * Q1};               // exact radius
      8:  d = '{0, 0, CoordMax, 0, 0, CoordMin};
      9:  d = '{0, 0, CoordMin, 0, 0, CoordMax};
      10: d = '{-1, -1, -1, 2, 2, 2};
      default: d = '{CoordMin, 0, 0, -1, 0, 0};
    endcase
    return d;
  endfunction

  task automatic push_item(input pvcp_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CfgIdxW-1:0] idx,
                            input logic [CfgDataW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : watchdog
    int quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] cfg_word;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_on        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, RegProjMode, '0);
    for (int k = 0; k < NumCorners; k++) push_item(corner_item(k));
    drain();
    cfg_access(1'b1, RegProjMode, 32'h0000_0001);
    cfg_access(1'b0, RegProjMode, '0);
    for (int k = 0; k < NumCorners; k++) push_item(corner_item(k));
    drain();
    cfg_access(1'b1, RegUnmapped, 32'h0000_0000);
    cfg_access(1'b0, RegProjMode, '0);

    // output held off long enough for the pipeline to back up into in_ready
    fork
      begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (FillItems) push_item(random_item());
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cfg_word = 32'h0000_0000;
        1: cfg_word = 32'hFFFF_FFFF;
        2: cfg_word = 32'h0000_0001;
        3: cfg_word = 32'hFFFF_FFFE;
        default: begin
          cfg_word    = $urandom;
          cfg_word[0] = (p == 4 || p == 7);
        end
      endcase
      cfg_access(1'b1, RegProjMode, cfg_word);
      if (p % 3 == 2) cfg_access(1'b1, RegUnmapped, $urandom);
      cfg_access(1'b0, RegProjMode, '0);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      repeat (PhaseItems) push_item(random_item());
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pvcp_pkg.sv
src/pvcp_front.sv
src/pvcp_sqrt_cell.sv
src/pvcp_back.sv
src/point_vector_cylinder_projection_unit.sv
tb/projection_checker.sv
tb/testbench.sv
